/* design/cpfe_pkg.sv */
`timescale 1ns / 1ps
package cpfe_pkg;

  // default import table depth
  localparam int IMPORT_DEPTH_DEF = 1024;

  // command codes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_FIX   = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ORDINAL = 3'd1,
    ST_MULTI       = 3'd2,
    ST_NO_CHAIN    = 3'd3,
    ST_NOT_ACTIVE  = 3'd4
  } status_t;

  // configuration register indexes
  localparam logic [2:0] REG_IMAGE_BASE    = 3'd0;
  localparam logic [2:0] REG_SLIDE         = 3'd1;
  localparam logic [2:0] REG_OFFSET_FORMAT = 3'd2;
  localparam logic [2:0] REG_PAGE_BYTES    = 3'd3;
  localparam logic [2:0] REG_IMPORT_COUNT  = 3'd4;

  // configuration reset values
  localparam logic [63:0] IMAGE_BASE_RST    = 64'd0;
  localparam logic [63:0] SLIDE_RST         = 64'd0;
  localparam logic        OFFSET_FORMAT_RST = 1'b1;
  localparam logic [15:0] PAGE_BYTES_RST    = 16'd16384;
  localparam logic [10:0] IMPORT_COUNT_RST  = 11'd0;

  // chained pointer layout
  localparam logic [15:0] START_NONE = 16'hFFFF;
  localparam int NEXT_LSB    = 51;
  localparam int NEXT_W      = 12;
  localparam int ORD_W       = 24;
  localparam int ADD8_LSB    = 24;
  localparam int TARGET_W    = 36;
  localparam int HIGH8_LSB   = 36;
  localparam int HIGH8_POS   = 56;

  // one import table entry
  typedef struct packed {
    logic [63:0] value;
    logic [31:0] addend;
    logic        found;
  } import_entry_t;

endpackage

/* design/cpfe_ifs.sv */
`timescale 1ns / 1ps
// command channel
interface cpfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [9:0]  import_index;
  logic [63:0] import_value;
  logic        import_found;
  logic signed [31:0] import_addend;
  logic [63:0] seg_offset;
  logic [15:0] page_index;
  logic [15:0] first_fixup;
  logic [63:0] raw_word;

  modport source (
    output valid, cmd, import_index, import_value, import_found, import_addend,
    output seg_offset, page_index, first_fixup, raw_word,
    input  ready
  );
  modport sink (
    input  valid, cmd, import_index, import_value, import_found, import_addend,
    input  seg_offset, page_index, first_fixup, raw_word,
    output ready
  );
endinterface

// result channel
interface cpfe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] word_address;
  logic [63:0] fixed_value;
  logic        was_bind;
  logic        chain_last;
  logic [2:0]  status;

  modport source (
    output valid, word_address, fixed_value, was_bind, chain_last, status,
    input  ready
  );
  modport sink (
    input  valid, word_address, fixed_value, was_bind, chain_last, status,
    output ready
  );
endinterface

// configuration write channel
interface cpfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [63:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* design/cpfe_import_ram.sv */
`timescale 1ns / 1ps
module cpfe_import_ram #(
  parameter int DEPTH = cpfe_pkg::IMPORT_DEPTH_DEF,
  parameter int AW    = 10
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  cpfe_pkg::import_entry_t wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output cpfe_pkg::import_entry_t rdata
);
  import cpfe_pkg::*;

  import_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/chained_pointer_fixup_engine_unit.sv */
`timescale 1ns / 1ps
// pipeline: two register stages; a command beat is registered in stage one at
//   accept and moves into the output register as stage one advances
// throughput: one command per cycle unless the output stalls; the import table
//   read starts at accept, and the chain address register updates as each command leaves stage one
// reset: clears chain state, pipeline valids and the configuration registers;
//   the import table is not cleared and holds garbage until loaded
module chained_pointer_fixup_engine_unit #(
  parameter int IMPORT_DEPTH = cpfe_pkg::IMPORT_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  cpfe_in_if.sink     in_ch,
  cpfe_out_if.source  out_ch,
  cpfe_cfg_if.sink    cfg_ch
);
  import cpfe_pkg::*;

  localparam int AW = (IMPORT_DEPTH > 1) ? $clog2(IMPORT_DEPTH) : 1;
  localparam logic [ORD_W:0] DEPTH_W = (ORD_W + 1)'(IMPORT_DEPTH);

  // configuration registers
  logic [63:0] image_base;
  logic [63:0] slide;
  logic        offset_format;
  logic [15:0] page_bytes;
  logic [10:0] import_count;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_base    <= IMAGE_BASE_RST;
      slide         <= SLIDE_RST;
      offset_format <= OFFSET_FORMAT_RST;
      page_bytes    <= PAGE_BYTES_RST;
      import_count  <= IMPORT_COUNT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_IMAGE_BASE:    image_base    <= cfg_ch.wdata;
        REG_SLIDE:         slide         <= cfg_ch.wdata;
        REG_OFFSET_FORMAT: offset_format <= cfg_ch.wdata[0];
        REG_PAGE_BYTES:    page_bytes    <= cfg_ch.wdata[15:0];
        REG_IMPORT_COUNT:  import_count  <= cfg_ch.wdata[10:0];
        default: ;
      endcase
    end
  end

  // handshake control
  logic s1_valid;
  logic out_valid;
  logic s1_adv;
  logic in_ready;
  logic in_acc;

  assign s1_adv   = !out_valid || out_ch.ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_acc   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // import table: written and read at accept
  logic          tbl_we;
  logic          tbl_re;
  import_entry_t tbl_wdata;
  import_entry_t tbl_rdata;

  assign tbl_we = in_acc && (in_ch.cmd == CMD_LOAD) &&
                  ((ORD_W + 1)'(in_ch.import_index) < DEPTH_W);
  assign tbl_re = in_acc;
  assign tbl_wdata.value  = in_ch.import_value;
  assign tbl_wdata.addend = in_ch.import_addend;
  assign tbl_wdata.found  = in_ch.import_found;

  cpfe_import_ram #(
    .DEPTH (IMPORT_DEPTH),
    .AW    (AW)
  ) u_import_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_ch.import_index)),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (AW'(in_ch.raw_word[ORD_W-1:0])),
    .rdata (tbl_rdata)
  );

  // stage one registers
  logic [1:0]  s1_cmd;
  logic [15:0] s1_start;
  logic [63:0] s1_raw;
  logic [63:0] s1_base;
  logic [31:0] s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  // partial chain start address and page offset product
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd   <= in_ch.cmd;
      s1_start <= in_ch.first_fixup;
      s1_raw   <= in_ch.raw_word;
      s1_base  <= image_base + in_ch.seg_offset + 64'(in_ch.first_fixup);
      s1_prod  <= 32'(in_ch.page_index) * 32'(page_bytes);
    end
  end

  // chain state
  logic [63:0] cur_addr;
  logic [63:0] cur_addr_next;
  logic        chain_active;
  logic        chain_active_next;

  // decoded chain word
  logic [63:0]       start_addr;
  logic [NEXT_W-1:0] nxt;
  logic [ORD_W-1:0]  ord;
  logic              is_bind;
  logic              ord_bad;
  logic [63:0]       bind_val;
  logic [63:0]       rebase_tgt;
  logic [63:0]       rebase_val;

  assign start_addr = s1_base + 64'(s1_prod);
  assign nxt        = s1_raw[NEXT_LSB +: NEXT_W];
  assign ord        = s1_raw[ORD_W-1:0];
  assign is_bind    = s1_raw[63];
  assign ord_bad    = (ord >= ORD_W'(import_count)) || ({1'b0, ord} >= DEPTH_W);
  assign bind_val   = tbl_rdata.found ?
                      (tbl_rdata.value + 64'(s1_raw[ADD8_LSB +: 8]) +
                       {{32{tbl_rdata.addend[31]}}, tbl_rdata.addend}) : 64'd0;
  assign rebase_tgt = offset_format ?
                      (image_base + 64'(s1_raw[TARGET_W-1:0])) :
                      (64'(s1_raw[TARGET_W-1:0]) + slide);
  assign rebase_val = rebase_tgt | {s1_raw[HIGH8_LSB +: 8], 56'd0};

  // result of the command in stage one
  logic [63:0] r_addr;
  logic [63:0] r_val;
  logic        r_bind;
  logic        r_last;
  status_t     r_status;

  always_comb begin
    r_addr            = 64'd0;
    r_val             = 64'd0;
    r_bind            = 1'b0;
    r_last            = 1'b0;
    r_status          = ST_OK;
    cur_addr_next     = cur_addr;
    chain_active_next = chain_active;
    case (s1_cmd)
      CMD_START: begin
        if (s1_start == START_NONE) begin
          r_status          = ST_NO_CHAIN;
          chain_active_next = 1'b0;
        end else if (s1_start[15]) begin
          r_addr            = start_addr;
          r_status          = ST_MULTI;
          chain_active_next = 1'b0;
        end else begin
          r_addr            = start_addr;
          cur_addr_next     = start_addr;
          chain_active_next = 1'b1;
        end
      end
      CMD_FIX: begin
        if (!chain_active) begin
          r_status = ST_NOT_ACTIVE;
        end else if (is_bind && ord_bad) begin
          r_addr            = cur_addr;
          r_bind            = 1'b1;
          r_last            = 1'b1;
          r_status          = ST_BAD_ORDINAL;
          chain_active_next = 1'b0;
        end else begin
          r_addr = cur_addr;
          r_val  = is_bind ? bind_val : rebase_val;
          r_bind = is_bind;
          r_last = (nxt == '0);
          if (nxt == '0) begin
            chain_active_next = 1'b0;
          end else begin
            cur_addr_next = cur_addr + 64'({nxt, 2'b00});
          end
        end
      end
      default: ;
    endcase
  end

  // chain state advances as the command leaves stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr     <= 64'd0;
      chain_active <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      cur_addr     <= cur_addr_next;
      chain_active <= chain_active_next;
    end
  end

  // output register
  logic [63:0] o_addr;
  logic [63:0] o_val;
  logic        o_bind;
  logic        o_last;
  status_t     o_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      o_addr   <= r_addr;
      o_val    <= r_val;
      o_bind   <= r_bind;
      o_last   <= r_last;
      o_status <= r_status;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.word_address = o_addr;
  assign out_ch.fixed_value  = o_val;
  assign out_ch.was_bind     = o_bind;
  assign out_ch.chain_last   = o_last;
  assign out_ch.status       = o_status;

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a chain end shown at the output has already dropped the chain
  a_last_drops_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_last |-> !chain_active)
    else $error("chain still active after last word");

  // a bad ordinal result has aborted the chain
  a_bad_ord_aborts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (o_status == ST_BAD_ORDINAL) |-> !chain_active)
    else $error("chain still active after bad ordinal");

  // a stalled stage one keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_raw))
    else $error("stage one changed while stalled");

endmodule

/* bench/cpfe_fixup_checker.sv */
`timescale 1ns / 1ps
module cpfe_fixup_checker #(
  parameter int IMPORT_DEPTH = cpfe_pkg::IMPORT_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  cpfe_in_if   in_ch,
  cpfe_out_if  out_ch,
  cpfe_cfg_if  cfg_ch,
  output int   pending,
  output int   errors
);
  import cpfe_pkg::*;

  typedef struct packed {
    logic [63:0] word_address;
    logic [63:0] fixed_value;
    logic        was_bind;
    logic        chain_last;
    status_t     status;
  } fixup_t;

  // shadow import table
  logic [63:0] entry_value  [IMPORT_DEPTH];
  logic [31:0] entry_addend [IMPORT_DEPTH];
  logic        entry_found  [IMPORT_DEPTH];

  // chain walker and register shadow
  logic [63:0] walk_addr;
  logic        walk_active;
  logic [63:0] cfg_image_base;
  logic [63:0] cfg_slide;
  logic        cfg_offset_fmt;
  logic [15:0] cfg_page_bytes;
  logic [10:0] cfg_import_count;

  fixup_t      fixups_due [$];
  fixup_t      want;

  // expected result of the command beat now on the input channel
  function automatic fixup_t predict_fixup();
    fixup_t      r;
    logic [63:0] raw;
    logic [11:0] next;
    logic [23:0] ord;
    logic [63:0] target;
    r = '0;
    raw = in_ch.raw_word;
    case (in_ch.cmd)
      CMD_LOAD: begin
        entry_value[in_ch.import_index]  = in_ch.import_value;
        entry_found[in_ch.import_index]  = in_ch.import_found;
        entry_addend[in_ch.import_index] = in_ch.import_addend;
      end
      CMD_START: begin
        if (in_ch.first_fixup == START_NONE) begin
          walk_active = 1'b0;
          r.status = ST_NO_CHAIN;
        end else begin
          r.word_address = cfg_image_base + in_ch.seg_offset
                         + 64'(in_ch.page_index) * 64'(cfg_page_bytes)
                         + 64'(in_ch.first_fixup);
          if (in_ch.first_fixup[15]) begin
            walk_active = 1'b0;
            r.status = ST_MULTI;
          end else begin
            walk_addr = r.word_address;
            walk_active = 1'b1;
          end
        end
      end
      CMD_FIX: begin
        if (!walk_active) begin
          r.status = ST_NOT_ACTIVE;
        end else begin
          next = raw[NEXT_LSB +: NEXT_W];
          r.word_address = walk_addr;
          r.was_bind = raw[63];
          if (raw[63]) begin
            ord = raw[ORD_W-1:0];
            if (ord >= cfg_import_count || ord >= IMPORT_DEPTH) begin
              // bad ordinal aborts the walk
              walk_active = 1'b0;
              r.chain_last = 1'b1;
              r.status = ST_BAD_ORDINAL;
            end else if (entry_found[ord]) begin
              r.fixed_value = entry_value[ord] + 64'(raw[ADD8_LSB +: 8])
                            + {{32{entry_addend[ord][31]}}, entry_addend[ord]};
            end
          end else begin
            target = 64'(raw[TARGET_W-1:0]);
            r.fixed_value = (cfg_offset_fmt ? cfg_image_base + target : target + cfg_slide)
                          | {raw[HIGH8_LSB +: 8], 56'd0};
          end
          if (r.status == ST_OK) begin
            r.chain_last = (next == '0);
            if (next == '0) walk_active = 1'b0;
            else walk_addr = walk_addr + (64'(next) << 2);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // watch config writes, command beats and result beats
  always @(posedge clk) begin
    if (rst) begin
      walk_addr = '0;
      walk_active = 1'b0;
      cfg_image_base = IMAGE_BASE_RST;
      cfg_slide = SLIDE_RST;
      cfg_offset_fmt = OFFSET_FORMAT_RST;
      cfg_page_bytes = PAGE_BYTES_RST;
      cfg_import_count = IMPORT_COUNT_RST;
      fixups_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_IMAGE_BASE:    cfg_image_base = cfg_ch.wdata;
          REG_SLIDE:         cfg_slide = cfg_ch.wdata;
          REG_OFFSET_FORMAT: cfg_offset_fmt = cfg_ch.wdata[0];
          REG_PAGE_BYTES:    cfg_page_bytes = cfg_ch.wdata[15:0];
          REG_IMPORT_COUNT:  cfg_import_count = cfg_ch.wdata[10:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) fixups_due.push_back(predict_fixup());
      if (out_ch.valid && out_ch.ready) begin
        if (fixups_due.size() == 0) begin
          $error("result beat with no command outstanding, address %h",
                 out_ch.word_address);
          errors++;
        end else begin
          want = fixups_due.pop_front();
          check_field("word_address", want.word_address, out_ch.word_address);
          check_field("fixed_value", want.fixed_value, 64'(out_ch.fixed_value));
          check_field("was_bind", 64'(want.was_bind), 64'(out_ch.was_bind));
          check_field("chain_last", 64'(want.chain_last), 64'(out_ch.chain_last));
          check_field("status", 64'(want.status), 64'(out_ch.status));
        end
      end
    end
    pending = fixups_due.size();
  end

endmodule

/* bench/chained_pointer_fixup_engine_unit_test.sv */
`timescale 1ns / 1ps
module chained_pointer_fixup_engine_unit_test;
  import cpfe_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 125;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    cmd_t        cmd;
    logic [9:0]  import_index;
    logic [63:0] import_value;
    logic        import_found;
    logic [31:0] import_addend;
    logic [63:0] seg_offset;
    logic [15:0] page_index;
    logic [15:0] first_fixup;
    logic [63:0] raw_word;
  } cmd_beat_t;

  logic        clk;
  logic        rst;
  int          pending;
  int          errors;
  bit          calm;
  bit          hold_req;
  bit          entry_loaded [1024];
  int          loaded_idx [$];
  logic [10:0] cur_count;
  int          sent;

  cpfe_in_if  in_ch ();
  cpfe_out_if out_ch ();
  cpfe_cfg_if cfg_ch ();

  chained_pointer_fixup_engine_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cpfe_fixup_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .pending (pending),
    .errors  (errors)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin
    #20_000_000;
    $display("chained_pointer_fixup_engine_unit_test: errors");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // command beat with every field random apart from the command
  function automatic cmd_beat_t fresh_beat(input cmd_t c);
    cmd_beat_t b;
    b.cmd            = c;
    b.import_index   = 10'($urandom());
    b.import_value   = rand64();
    b.import_found   = 1'($urandom_range(0, 1));
    b.import_addend  = $urandom();
    b.seg_offset     = rand64();
    b.page_index     = 16'($urandom());
    b.first_fixup    = 16'($urandom());
    b.raw_word       = rand64();
    return b;
  endfunction

  // ordinal of a loaded live entry, or a bad one at or beyond the live count
  function automatic logic [23:0] pick_ordinal(input bit want_bad);
    int k;
    int t;
    if (!want_bad && loaded_idx.size() > 0) begin
      for (t = 0; t < 16; t++) begin
        k = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
        if (k < cur_count) return 24'(k);
      end
    end
    case ($urandom_range(0, 2))
      0:       return 24'(cur_count);
      1:       return 24'hFFFFFF;
      default: return 24'($urandom_range(cur_count, 24'hFFFFFF));
    endcase
  endfunction

  // raw chained word with random content; binds never hit an unloaded entry
  function automatic logic [63:0] chain_word(input bit last, input bit allow_bad);
    logic [63:0] w;
    w = rand64();
    w[NEXT_LSB +: NEXT_W] = last ? 12'd0 : 12'($urandom_range(1, 4095));
    if (w[63]) w[ORD_W-1:0] = pick_ordinal(allow_bad && $urandom_range(0, 11) == 0);
    return w;
  endfunction

  // drive one command beat and wait for it to be taken
  task automatic issue(input cmd_beat_t b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= b.cmd;
    in_ch.import_index   <= b.import_index;
    in_ch.import_value   <= b.import_value;
    in_ch.import_found   <= b.import_found;
    in_ch.import_addend  <= b.import_addend;
    in_ch.seg_offset     <= b.seg_offset;
    in_ch.page_index     <= b.page_index;
    in_ch.first_fixup    <= b.first_fixup;
    in_ch.raw_word       <= b.raw_word;
    if (b.cmd == CMD_LOAD && !entry_loaded[b.import_index]) begin
      entry_loaded[b.import_index] = 1'b1;
      loaded_idx.push_back(int'(b.import_index));
    end
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic load_entry(input logic [9:0] idx);
    cmd_beat_t b;
    b = fresh_beat(CMD_LOAD);
    b.import_index = idx;
    issue(b);
  endtask

  // stop sending until every result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic cfg_beat(input logic [2:0] idx, input logic [63:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // registers change only with the block idle
  task automatic configure(input logic [63:0] base, input logic [63:0] slide_v,
                           input logic fmt, input logic [15:0] psize,
                           input logic [10:0] count);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_beat(REG_IMAGE_BASE, base);
    cfg_beat(REG_SLIDE, slide_v);
    cfg_beat(REG_OFFSET_FORMAT, 64'(fmt));
    cfg_beat(REG_PAGE_BYTES, 64'(psize));
    cfg_beat(REG_IMPORT_COUNT, 64'(count));
    cfg_ch.valid <= 1'b0;
    cur_count = count;
    @(negedge clk);
  endtask

  // well-formed chain: start then words, sometimes cut short
  task automatic run_chain();
    cmd_beat_t b;
    int len;
    int i;
    b = fresh_beat(CMD_START);
    b.first_fixup[15] = 1'b0;
    issue(b);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
    for (i = 0; i < len; i++) begin
      b = fresh_beat(CMD_FIX);
      b.raw_word = chain_word(i == len - 1, 1'b1);
      issue(b);
      if (b.raw_word[63] && b.raw_word[23:0] >= 24'(cur_count)) break;
      if (i < len - 1 && $urandom_range(0, 19) == 0) break;
    end
  endtask

  // stray starts, loads and words outside a chain
  task automatic send_noise();
    cmd_beat_t b;
    case ($urandom_range(0, 4))
      0: begin
        b = fresh_beat(CMD_START);
        b.first_fixup = START_NONE;
      end
      1: begin
        b = fresh_beat(CMD_START);
        b.first_fixup[15] = 1'b1;
        if (b.first_fixup == START_NONE) b.first_fixup = 16'h8000;
      end
      2: b = fresh_beat(CMD_LOAD);
      default: begin
        b = fresh_beat(CMD_FIX);
        b.raw_word = chain_word(1'($urandom_range(0, 1)), 1'b1);
      end
    endcase
    issue(b);
  endtask

  // stimulus and verdict
  initial begin
    cmd_beat_t b;
    int waited;
    int r;
    int goal;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_LOAD;
    in_ch.import_index   = '0;
    in_ch.import_value   = '0;
    in_ch.import_found   = 1'b0;
    in_ch.import_addend  = '0;
    in_ch.seg_offset     = '0;
    in_ch.page_index     = '0;
    in_ch.first_fixup    = '0;
    in_ch.raw_word       = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.reg_index     = REG_IMAGE_BASE;
    cfg_ch.wdata         = '0;
    calm                 = 1'b0;
    hold_req             = 1'b0;
    cur_count            = IMPORT_COUNT_RST;
    sent                 = 0;
    rst                  = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // word with nothing started
    b = fresh_beat(CMD_FIX);
    issue(b);
    configure(64'h0000_0001_0000_0000, 64'hFFFF_FFFF_FFFF_F000, 1'b1, 16'd16384,
              11'd1024);

    // table extremes and an unresolved import
    b = fresh_beat(CMD_LOAD);
    b.import_index = 10'd0;
    b.import_value = '1;
    b.import_found = 1'b1;
    b.import_addend = 32'h8000_0000;
    issue(b);
    b = fresh_beat(CMD_LOAD);
    b.import_index = 10'd1023;
    b.import_value = '0;
    b.import_found = 1'b1;
    b.import_addend = 32'h7FFF_FFFF;
    issue(b);
    b = fresh_beat(CMD_LOAD);
    b.import_index = 10'd5;
    b.import_found = 1'b0;
    issue(b);

    // page with no chain, multi starts
    b = fresh_beat(CMD_START);
    b.first_fixup = START_NONE;
    issue(b);
    b = fresh_beat(CMD_START);
    b.first_fixup = 16'h8000;
    issue(b);
    b = fresh_beat(CMD_START);
    b.first_fixup = 16'hFFFE;
    issue(b);

    // start that wraps the address space, then binds and rebases to the end
    b = fresh_beat(CMD_START);
    b.seg_offset = '1;
    b.page_index = 16'hFFFF;
    b.first_fixup = 16'h7FFF;
    issue(b);
    b = fresh_beat(CMD_FIX);
    b.raw_word = {1'b1, 12'd1, 19'h7FFFF, 8'hFF, 24'd0};
    issue(b);
    b.raw_word = {1'b1, 12'hFFF, 19'd0, 8'h00, 24'd1023};
    issue(b);
    b.raw_word = {1'b1, 12'd2, 19'h2AAAA, 8'h80, 24'd5};
    issue(b);
    b.raw_word = {1'b0, 12'd3, 7'h7F, 8'hFF, 36'hF_FFFF_FFFF};
    issue(b);
    b.raw_word = {1'b0, 12'd0, 7'h00, 8'h00, 36'd0};
    issue(b);

    // word after the chain ended
    b = fresh_beat(CMD_FIX);
    issue(b);

    // bad ordinals: just past the table and the widest value
    b = fresh_beat(CMD_START);
    b.seg_offset = '0;
    b.page_index = 16'd0;
    b.first_fixup = 16'd0;
    issue(b);
    b = fresh_beat(CMD_FIX);
    b.raw_word = {1'b1, 12'd7, 19'd0, 8'd0, 24'd1024};
    issue(b);
    b = fresh_beat(CMD_FIX);
    issue(b);
    b = fresh_beat(CMD_START);
    b.first_fixup[15] = 1'b0;
    issue(b);
    b = fresh_beat(CMD_FIX);
    b.raw_word = {1'b1, 12'd0, 19'h7FFFF, 8'hFF, 24'hFFFFFF};
    issue(b);

    // random phases, register extremes first
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure('1, 64'h8000_0000_0000_0000, 1'b0, 16'hFFFF, 11'd1024);
        1: configure('0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 16'd1, 11'd1);
        2: configure(rand64(), rand64(), 1'b1, 16'hFFFF, 11'd0);
        default: configure(rand64(), rand64(), 1'($urandom_range(0, 1)),
                           16'($urandom_range(1, 65535)), 11'($urandom_range(0, 1024)));
      endcase
      calm = (p == PHASES - 1);
      if (p == 1) hold_req = 1'b1;
      // a few live entries so that good binds exist
      repeat (6) begin
        if (cur_count == 0) load_entry(10'($urandom_range(0, 1023)));
        else load_entry(10'($urandom_range(0, cur_count - 1)));
      end
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        r = $urandom_range(0, 19);
        if (r < 14) run_chain();
        else if (r < 18) send_noise();
        else if (r == 18) load_entry(10'($urandom()));
        else drain_results();
      end
    end

    // wait out the last results
    in_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    if (pending != 0) begin
      $display("chained_pointer_fixup_engine_unit_test: errors");
      $finish;
    end else begin
      repeat (8) @(negedge clk);
      if (errors == 0) begin
        $display("chained_pointer_fixup_engine_unit_test: clean");
      end else begin
        $display("chained_pointer_fixup_engine_unit_test: errors");
      end
      $finish;
    end
  end

endmodule
